### hdl/asic_unlock_sequence_detector_defines.svh
// assertion macros for the unlock sequence detector
`ifndef ASIC_UNLOCK_SEQUENCE_DETECTOR_DEFINES_SVH
`define ASIC_UNLOCK_SEQUENCE_DETECTOR_DEFINES_SVH

// same-cycle implication
`define UNLSEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("unlock sequence check failed");

// next-cycle implication
`define UNLSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("unlock sequence check failed");

`endif

### hdl/unlseq_pkg.sv
// shared types, constants and the unlock byte table
`default_nettype none

package unlseq_pkg;

   typedef logic [4:0] seq_pos_type;
   typedef logic [3:0] seq_idx_type;

   typedef struct packed {
      logic        unlocked;
      logic        crtc_write;
      logic        gate_array_tick;
      seq_pos_type position;
   } step_result_type;

   localparam logic [15:0] ADDR_SEL_MASK  = 16'h4300;
   localparam logic [15:0] CRTC_SEL_LOW   = 16'h0000;
   localparam logic [15:0] CRTC_SEL_HIGH  = 16'h0100;
   localparam logic [15:0] GA_HI_MASK     = 16'hC000;
   localparam logic [15:0] GA_HI_MATCH    = 16'h4000;
   localparam logic [15:0] GA_BIT15_MASK  = 16'h8000;
   localparam logic [15:0] GA_BIT13_MASK  = 16'h2000;
   localparam logic [7:0]  CHECK_BYTE     = 8'hCD;

   localparam seq_pos_type POS_IDLE      = 5'd0;
   localparam seq_pos_type POS_SYNC      = 5'd1;
   localparam seq_pos_type POS_FIRST_CMP = 5'd2;
   localparam seq_pos_type POS_LAST_CMP  = 5'd14;
   localparam seq_pos_type POS_CHECK     = 5'd15;
   localparam seq_pos_type POS_FINAL     = 5'd16;

   function automatic logic [7:0] seq_byte(input seq_idx_type idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'hFF;
         4'd1:    b = 8'h77;
         4'd2:    b = 8'hB3;
         4'd3:    b = 8'h51;
         4'd4:    b = 8'hA8;
         4'd5:    b = 8'hD4;
         4'd6:    b = 8'h62;
         4'd7:    b = 8'h39;
         4'd8:    b = 8'h9C;
         4'd9:    b = 8'h46;
         4'd10:   b = 8'h2B;
         4'd11:   b = 8'h15;
         4'd12:   b = 8'h8A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

### hdl/asic_unlock_sequence_detector.sv
// top level of the unlock sequence detector: request register, step logic, result register
//
// usage:
//   each request is one cpu i/o access (opcode, port_address, write_byte),
//   taken at a rising edge with req_valid high and req_stall low
//   every request produces exactly one result on the rsp_ channel, in order,
//   taken at a rising edge with rsp_valid high and rsp_stall low
//   the request register holds a taken request until the result register is free,
//   and the result register then loads the step result for it
//   throughput: one request per cycle while rsp_stall is low, through the combinational
//   step logic that updates the position and unlock flag between the two registers
//   when the receiver stalls, the result holds; one more request waits in the
//   request register, and req_stall rises only while both registers are full
//   and rsp_stall is high
//   reset (synchronous, active high) empties both registers, sets the
//   sequence position to 0 and locks the extended features
`default_nettype none

`include "asic_unlock_sequence_detector_defines.svh"

module asic_unlock_sequence_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_port_address,
   input  wire logic [7:0]  req_write_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_unlocked,
   output logic             rsp_crtc_write,
   output logic             rsp_gate_array_tick,
   output logic [4:0]       rsp_seq_position
);

   logic                        req_valid_ff;
   logic                        opcode_ff;
   logic [15:0]                 port_address_ff;
   logic [7:0]                  write_byte_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   unlseq_pkg::step_result_type rsp_ff;
   unlseq_pkg::step_result_type step;
   unlseq_pkg::seq_pos_type     position_ff;
   logic                        unlock_flag_ff;
   logic                        rsp_free;
   logic                        req_move;
   logic                        req_take;

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign req_move     = req_valid_ff && rsp_free;
   assign req_stall    = req_valid_ff && !rsp_free;
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid_in = req_move || (rsp_valid_ff && rsp_stall);

   unlseq_step u_step (
      .position     (position_ff),
      .unlocked     (unlock_flag_ff),
      .opcode       (opcode_ff),
      .port_address (port_address_ff),
      .write_byte   (write_byte_ff),
      .result       (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         position_ff    <= unlseq_pkg::POS_IDLE;
         unlock_flag_ff <= 1'b0;
      end else begin
         if (req_take || req_move) begin
            req_valid_ff <= req_take;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (req_move) begin
            position_ff    <= step.position;
            unlock_flag_ff <= step.unlocked;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff       <= req_opcode;
         port_address_ff <= req_port_address;
         write_byte_ff   <= req_write_byte;
      end
      if (req_move) begin
         rsp_ff <= step;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_unlocked        = rsp_ff.unlocked;
   assign rsp_crtc_write      = rsp_ff.crtc_write;
   assign rsp_gate_array_tick = rsp_ff.gate_array_tick;
   assign rsp_seq_position    = rsp_ff.position;

   `UNLSEQ_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, position_ff <= unlseq_pkg::POS_FINAL)
   `UNLSEQ_ASSERT_NEXT(a_hold_no_crtc, clock, reset, req_move && !step.crtc_write, $stable(position_ff) && $stable(unlock_flag_ff))
   `UNLSEQ_ASSERT_NOW(a_unlock_after_final, clock, reset, $rose(unlock_flag_ff), $past(position_ff) == unlseq_pkg::POS_FINAL)
   `UNLSEQ_ASSERT_NEXT(a_rsp_state_match, clock, reset, req_move, rsp_seq_position == position_ff && rsp_unlocked == unlock_flag_ff)

endmodule

`default_nettype wire

### hdl/unlseq_step.sv
// next sequence position, unlock flag and address decode for one request
`default_nettype none

module unlseq_step (
   input  wire unlseq_pkg::seq_pos_type     position,
   input  wire logic                        unlocked,
   input  wire logic                        opcode,
   input  wire logic [15:0]                 port_address,
   input  wire logic [7:0]                  write_byte,
   output unlseq_pkg::step_result_type      result
);

   logic [15:0]             sel;
   logic                    crtc;
   logic                    byte_zero;
   unlseq_pkg::seq_idx_type idx;
   unlseq_pkg::seq_pos_type seq_next;
   unlseq_pkg::seq_pos_type miss_pos;
   logic                    flag_next;

   assign sel       = port_address & unlseq_pkg::ADDR_SEL_MASK;
   assign crtc      = opcode && ((sel == unlseq_pkg::CRTC_SEL_LOW) ||
                                 (sel == unlseq_pkg::CRTC_SEL_HIGH));
   assign byte_zero = (write_byte == 8'h00);
   assign idx       = unlseq_pkg::seq_idx_type'(position - unlseq_pkg::POS_FIRST_CMP);
   assign miss_pos  = byte_zero ? unlseq_pkg::POS_FIRST_CMP : unlseq_pkg::POS_SYNC;

   always_comb begin
      flag_next = unlocked;
      priority if (position == unlseq_pkg::POS_IDLE) begin
         seq_next = byte_zero ? unlseq_pkg::POS_IDLE : unlseq_pkg::POS_SYNC;
      end else if (position == unlseq_pkg::POS_SYNC) begin
         seq_next = byte_zero ? unlseq_pkg::POS_FIRST_CMP : unlseq_pkg::POS_SYNC;
      end else if (position <= unlseq_pkg::POS_LAST_CMP) begin
         seq_next = (write_byte == unlseq_pkg::seq_byte(idx)) ? position + 5'd1 : miss_pos;
      end else if (position == unlseq_pkg::POS_CHECK) begin
         if (write_byte == unlseq_pkg::CHECK_BYTE) begin
            seq_next = unlseq_pkg::POS_FINAL;
         end else begin
            seq_next  = unlseq_pkg::POS_IDLE;
            flag_next = 1'b0;
         end
      end else if (position == unlseq_pkg::POS_FINAL) begin
         seq_next  = unlseq_pkg::POS_IDLE;
         flag_next = 1'b1;
      end else begin
         seq_next = unlseq_pkg::POS_IDLE;
      end
   end

   always_comb begin
      result.crtc_write      = crtc;
      result.position        = crtc ? seq_next : position;
      result.unlocked        = crtc ? flag_next : unlocked;
      result.gate_array_tick =
         ((port_address & unlseq_pkg::GA_HI_MASK) == unlseq_pkg::GA_HI_MATCH) ||
         ((port_address & unlseq_pkg::GA_BIT15_MASK) == 16'h0000) ||
         ((port_address & unlseq_pkg::GA_BIT13_MASK) == 16'h0000);
   end

endmodule

`default_nettype wire
